### rtl/core/y2r_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_pkg
// Shared types and constants for the packed 4:2:2 to RGB888 converter.
// ----------------------------------------------------------------------------
package y2r_pkg;

   // Register indexes on the csr port
   localparam logic REG_PIXEL_ORDER = 1'b0;
   localparam logic REG_OUTPUT_MODE = 1'b1;

   // Byte order codes
   localparam logic ORDER_YUYV = 1'b0;
   localparam logic ORDER_UYVY = 1'b1;

   // Output mode codes; the unused code behaves as gray
   localparam logic [1:0] MODE_RGB  = 2'd0;
   localparam logic [1:0] MODE_BGR  = 2'd1;
   localparam logic [1:0] MODE_GRAY = 2'd2;

   // Chroma weights in Q8
   localparam logic signed [10:0] COEF_RU = 11'sd520;
   localparam logic signed [10:0] COEF_GU = 11'sd101;
   localparam logic signed [10:0] COEF_GV = 11'sd149;
   localparam logic signed [10:0] COEF_BV = 11'sd292;

   // Q8 rounding bias (one half)
   localparam logic signed [18:0] Q8_HALF = 19'sd128;

   typedef struct packed {
      logic        end_of_buffer;
      logic [31:0] macropixel;
   } req_payload_type;

   typedef struct packed {
      logic       last_pair;
      logic [7:0] second_pixel_c;
      logic [7:0] second_pixel_b;
      logic [7:0] second_pixel_a;
      logic [7:0] first_pixel_c;
      logic [7:0] first_pixel_b;
      logic [7:0] first_pixel_a;
   } rsp_payload_type;

   // Rounded chroma terms shared by both pixels of a pair
   typedef struct packed {
      logic signed [9:0] tr;
      logic signed [9:0] tg;
      logic signed [9:0] tb;
   } chroma_terms_type;

   typedef struct packed {
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] c;
   } pixel_type;

endpackage

### rtl/core/yuv422_to_rgb_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv422_to_rgb_converter
// Packed 4:2:2 macropixel to two RGB888 / BGR888 / gray pixels.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one macropixel (four bytes) and an end-of-buffer flag.
//   rsp channel carries the two pixels of the pair and last_pair.
//   csr port: csr_index 0 sets pixel order (0 Y0 U Y1 V, 1 U Y0 V Y1),
//   csr_index 1 sets output mode (0 RGB, 1 BGR, 2 or 3 gray). Write only
//   while the block is idle.
// An accepted req transfer is registered in stage 1, then in the output
//   register. One macropixel per cycle while rsp_stall is low; two pipeline
//   stages: chroma multipliers in the first, both pixel lanes in the second.
// Reset (synchronous, active high) empties the pipeline and sets both
//   registers to zero.
// Stall: when rsp_stall holds, the result stays in the output register and
//   the first stage still takes one more item; req_stall rises once both
//   stages are full.
// ----------------------------------------------------------------------------
module yuv422_to_rgb_converter (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  y2r_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output y2r_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [1:0]               csr_data
);
   import y2r_pkg::*;

   // Configuration registers
   logic       order_ff;
   logic [1:0] mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_YUYV;
         mode_ff  <= MODE_RGB;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PIXEL_ORDER: order_ff <= csr_data[0];
            REG_OUTPUT_MODE: mode_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Stage handshake
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic s2_adv;
   logic s1_adv;
   logic req_take;

   assign s2_adv    = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign req_stall = !s1_adv;
   assign req_take  = req_valid && s1_adv;

   // Stage 1: unpack and chroma terms
   logic [7:0]       y0_c;
   logic [7:0]       y1_c;
   chroma_terms_type terms_c;

   y2r_chroma u_chroma (
      .macropixel  (req_payload.macropixel),
      .pixel_order (order_ff),
      .y0          (y0_c),
      .y1          (y1_c),
      .terms       (terms_c)
   );

   logic [7:0]       y0_ff;
   logic [7:0]       y1_ff;
   chroma_terms_type terms_ff;
   logic [1:0]       s1_mode_ff;
   logic             s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         y0_ff      <= y0_c;
         y1_ff      <= y1_c;
         terms_ff   <= terms_c;
         s1_mode_ff <= mode_ff;
         s1_last_ff <= req_payload.end_of_buffer;
      end
   end

   // Stage 2: two pixel lanes, merged into the output register
   pixel_type pix0;
   pixel_type pix1;

   y2r_lane u_lane0 (
      .luma        (y0_ff),
      .terms       (terms_ff),
      .output_mode (s1_mode_ff),
      .pixel       (pix0)
   );

   y2r_lane u_lane1 (
      .luma        (y1_ff),
      .terms       (terms_ff),
      .output_mode (s1_mode_ff),
      .pixel       (pix1)
   );

   rsp_payload_type rsp_in;
   rsp_payload_type rsp_ff;

   always_comb begin
      rsp_in.first_pixel_a  = pix0.a;
      rsp_in.first_pixel_b  = pix0.b;
      rsp_in.first_pixel_c  = pix0.c;
      rsp_in.second_pixel_a = pix1.a;
      rsp_in.second_pixel_b = pix1.b;
      rsp_in.second_pixel_c = pix1.c;
      rsp_in.last_pair      = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv && s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Checks
   a_take_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_valid_ff)
      else $error("accepted transfer did not reach stage 1");

   a_stall_needs_full: assert property (@(posedge clock)
      req_stall |-> s1_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("req_stall raised with room in the pipeline");

   a_s1_moves_out: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_adv |=> rsp_valid_ff)
      else $error("stage 1 item lost on its way to the output");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

### rtl/core/y2r_chroma.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_chroma
// Unpacks one macropixel and forms the three rounded chroma terms.
// ----------------------------------------------------------------------------
module y2r_chroma (
   input  logic [31:0]               macropixel,
   input  logic                      pixel_order,
   output logic [7:0]                y0,
   output logic [7:0]                y1,
   output y2r_pkg::chroma_terms_type terms
);
   import y2r_pkg::*;

   logic [7:0]         u_byte;
   logic [7:0]         v_byte;
   logic signed [8:0]  du;
   logic signed [8:0]  dv;
   logic signed [18:0] p_ru;
   logic signed [18:0] p_gu;
   logic signed [18:0] p_gv;
   logic signed [18:0] p_bv;
   logic signed [18:0] t_r;
   logic signed [18:0] t_g;
   logic signed [18:0] t_b;

   // Byte selection per pixel order
   always_comb begin
      unique case (pixel_order)
         ORDER_YUYV: begin
            y0     = macropixel[7:0];
            u_byte = macropixel[15:8];
            y1     = macropixel[23:16];
            v_byte = macropixel[31:24];
         end
         ORDER_UYVY: begin
            u_byte = macropixel[7:0];
            y0     = macropixel[15:8];
            v_byte = macropixel[23:16];
            y1     = macropixel[31:24];
         end
         default: begin
            y0     = macropixel[7:0];
            u_byte = macropixel[15:8];
            y1     = macropixel[23:16];
            v_byte = macropixel[31:24];
         end
      endcase
   end

   // Remove chroma offset: flipping the top bit gives byte - 128,
   // then sign-extend by one bit
   assign du = $signed({~u_byte[7], ~u_byte[7], u_byte[6:0]});
   assign dv = $signed({~v_byte[7], ~v_byte[7], v_byte[6:0]});

   // Constant-weight products
   assign p_ru = 19'(du) * 19'(COEF_RU);
   assign p_gu = 19'(du) * 19'(COEF_GU);
   assign p_gv = 19'(dv) * 19'(COEF_GV);
   assign p_bv = 19'(dv) * 19'(COEF_BV);

   // Round half up; floor by taking the upper bits
   assign t_r = p_ru + Q8_HALF;
   assign t_g = Q8_HALF - p_gu - p_gv;
   assign t_b = p_bv + Q8_HALF;

   assign terms.tr = t_r[17:8];
   assign terms.tg = t_g[17:8];
   assign terms.tb = t_b[17:8];

endmodule

### rtl/core/y2r_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_lane
// One pixel lane: adds chroma to luma, saturates, orders channels; gray: luma.
// ----------------------------------------------------------------------------
module y2r_lane (
   input  logic [7:0]                luma,
   input  y2r_pkg::chroma_terms_type terms,
   input  logic [1:0]                output_mode,
   output y2r_pkg::pixel_type        pixel
);
   import y2r_pkg::*;

   function automatic logic [7:0] sat8(input logic signed [10:0] v);
      logic [7:0] r;
      if (v < 0) begin
         r = 8'd0;
      end else if (v > 11'sd255) begin
         r = 8'd255;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   logic signed [10:0] luma_s;
   logic [7:0]         red;
   logic [7:0]         green;
   logic [7:0]         blue;

   assign luma_s = $signed({3'b000, luma});
   assign red    = sat8(luma_s + 11'(terms.tr));
   assign green  = sat8(luma_s + 11'(terms.tg));
   assign blue   = sat8(luma_s + 11'(terms.tb));

   // Channel order per mode
   always_comb begin
      unique case (output_mode)
         MODE_RGB: pixel = '{a: red, b: green, c: blue};
         MODE_BGR: pixel = '{a: blue, b: green, c: red};
         default:  pixel = '{a: luma, b: 8'd0, c: 8'd0};
      endcase
   end

endmodule
